[hdl/ptc_pkg.sv]
`timescale 1ns / 1ps

package ptc_pkg;

  // one raw reading pair
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } sample_t;

  // one compensated result
  typedef struct packed {
    logic signed [18:0] temperature;
    logic signed [31:0] pressure;
  } result_t;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // calibration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_COEFF        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_COEFF      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_TEMP          = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFF        = 3'd5;

  // band limits, in hundredths of a degree
  localparam logic signed [18:0] TEMP_BASE   = 19'sd2000;
  localparam logic signed [18:0] VLOW_LIMIT  = -19'sd3500;
  localparam logic signed [19:0] VLOW_OFFSET = 20'sd3500;

endpackage

[hdl/pressure_temperature_compensation_core.sv]
`timescale 1ns / 1ps

// an accepted reading pair moves through stage registers s1 to s10, and s10 drives the result
// throughput: one item per cycle while result_stall is low, set by the ten-stage datapath pipeline
// the 24x40 pressure product is split into two partial products over two stages
// reset clears all stage valid bits and the six calibration words to zero
// bubbles collapse, so a stalled result blocks earlier stages only once they are full

module pressure_temperature_compensation_core
  import ptc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NUM_STAGES = 10;

  // calibration words
  logic [15:0] sens_coeff;
  logic [15:0] offset_coeff;
  logic [15:0] sens_temp_coeff;
  logic [15:0] offset_temp_coeff;
  logic [15:0] ref_temp;
  logic [15:0] temp_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff        <= '0;
      offset_coeff      <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      ref_temp          <= '0;
      temp_coeff        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SENS_COEFF:        sens_coeff        <= cfg_data;
        REG_OFFSET_COEFF:      offset_coeff      <= cfg_data;
        REG_SENS_TEMP_COEFF:   sens_temp_coeff   <= cfg_data;
        REG_OFFSET_TEMP_COEFF: offset_temp_coeff <= cfg_data;
        REG_REF_TEMP:          ref_temp          <= cfg_data;
        REG_TEMP_COEFF:        temp_coeff        <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when empty or when it drains
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign sample_stall = !en[0];
  assign result_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: temperature difference
  logic signed [24:0] dt_c;
  logic signed [24:0] s1_dt;
  logic [23:0]        s1_d1;

  assign dt_c = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, ref_temp, 8'd0});

  // stage 2: products with the temperature difference
  logic signed [41:0] p_sens_c;
  logic signed [41:0] p_off_c;
  logic signed [41:0] p_temp_c;
  logic signed [49:0] dtsq_c;
  logic signed [41:0] s2_p_sens;
  logic signed [41:0] s2_p_off;
  logic signed [41:0] s2_p_temp;
  logic [47:0]        s2_dtsq;
  logic [23:0]        s2_d1;

  assign p_sens_c = $signed({1'b0, sens_temp_coeff}) * s1_dt;
  assign p_off_c  = $signed({1'b0, offset_temp_coeff}) * s1_dt;
  assign p_temp_c = $signed({1'b0, temp_coeff}) * s1_dt;
  assign dtsq_c   = s1_dt * s1_dt;

  // stage 3: first-order sensitivity, offset and temperature delta
  logic signed [41:0] sens_adj;
  logic signed [41:0] off_adj;
  logic signed [41:0] tq_adj;
  logic signed [39:0] sens_c;
  logic signed [39:0] off_c;
  logic signed [39:0] s3_sens;
  logic signed [39:0] s3_off;
  logic signed [18:0] s3_tq;
  logic [47:0]        s3_dtsq;
  logic [23:0]        s3_d1;

  // signed divides by powers of two truncate toward zero
  assign sens_adj = s2_p_sens + (s2_p_sens[41] ? 42'sd255 : 42'sd0);
  assign off_adj  = s2_p_off + (s2_p_off[41] ? 42'sd127 : 42'sd0);
  assign tq_adj   = s2_p_temp + (s2_p_temp[41] ? 42'sd8388607 : 42'sd0);
  assign sens_c   = $signed({9'd0, sens_coeff, 15'd0}) + 40'($signed(sens_adj[41:8]));
  assign off_c    = $signed({8'd0, offset_coeff, 16'd0}) + 40'($signed(off_adj[41:7]));

  // stage 4: squares, band decision, temperature correction
  logic signed [37:0] sq1_full;
  logic signed [19:0] tv_c;
  logic signed [39:0] sq2_full;
  logic [49:0]        ti3_c;
  logic [16:0]        ti_c;
  logic               low_c;
  logic [35:0]        s4_sq1;
  logic [35:0]        s4_sq2;
  logic               s4_low;
  logic               s4_vlow;
  logic signed [18:0] s4_temp;
  logic [16:0]        s4_ti;
  logic signed [39:0] s4_sens;
  logic signed [39:0] s4_off;
  logic [23:0]        s4_d1;

  assign low_c    = s3_tq[18];
  assign sq1_full = s3_tq * s3_tq;
  assign tv_c     = 20'(s3_tq) + VLOW_OFFSET;
  assign sq2_full = tv_c * tv_c;
  assign ti3_c    = {2'd0, s3_dtsq} + {1'b0, s3_dtsq, 1'b0};
  assign ti_c     = low_c ? ti3_c[49:33] : {5'd0, s3_dtsq[47:36]};

  // stage 5: second-order offset and sensitivity terms
  logic [37:0]        off_lo_c;
  logic [38:0]        seven_c;
  logic [37:0]        five_c;
  logic [39:0]        offi_c;
  logic [39:0]        sensi_c;
  logic signed [18:0] t_out_c;
  logic [39:0]        s5_offi;
  logic [39:0]        s5_sensi;
  logic signed [18:0] s5_t;
  logic signed [39:0] s5_sens;
  logic signed [39:0] s5_off;
  logic [23:0]        s5_d1;

  assign off_lo_c = {2'd0, s4_sq1} + {1'b0, s4_sq1, 1'b0};
  assign seven_c  = {s4_sq2, 3'd0} - {3'd0, s4_sq2};
  assign five_c   = {s4_sq1, 2'd0} + {2'd0, s4_sq1};

  always_comb begin
    if (s4_low) begin
      offi_c  = 40'(off_lo_c[37:1]) + (s4_vlow ? 40'(seven_c) : 40'd0);
      sensi_c = 40'(five_c[37:3]) + (s4_vlow ? 40'({s4_sq2, 2'd0}) : 40'd0);
    end else begin
      offi_c  = 40'(s4_sq1[35:4]);
      sensi_c = 40'd0;
    end
  end

  assign t_out_c = s4_temp - $signed({2'd0, s4_ti});

  // stage 6: corrected offset and sensitivity
  logic signed [39:0] s6_off2;
  logic signed [39:0] s6_sens2;
  logic signed [18:0] s6_t;
  logic [23:0]        s6_d1;

  // stage 7: partial products of the pressure term
  logic [43:0]        pl_c;
  logic signed [44:0] ph_c;
  logic [43:0]        s7_pl;
  logic signed [44:0] s7_ph;
  logic signed [39:0] s7_off2;
  logic signed [18:0] s7_t;

  assign pl_c = s6_d1 * s6_sens2[19:0];
  assign ph_c = $signed({1'b0, s6_d1}) * $signed(s6_sens2[39:20]);

  // stage 8: full pressure product
  logic signed [63:0] prod_c;
  logic signed [63:0] s8_prod;
  logic signed [39:0] s8_off2;
  logic signed [18:0] s8_t;

  assign prod_c = ($signed(64'(s7_ph)) <<< 20) + $signed({20'd0, s7_pl});

  // stage 9: scale and remove offset
  logic signed [63:0] q1_adj;
  logic signed [43:0] diff_c;
  logic signed [43:0] s9_diff;
  logic signed [18:0] s9_t;

  assign q1_adj = s8_prod + (s8_prod[63] ? 64'sd2097151 : 64'sd0);
  assign diff_c = 44'($signed(q1_adj[63:21])) - 44'(s8_off2);

  // stage 10: final scale into the output register
  logic signed [43:0] p_adj;
  result_t            s10_res;

  assign p_adj = s9_diff + (s9_diff[43] ? 44'sd8191 : 44'sd0);

  assign result = s10_res;

  // datapath registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_dt <= dt_c;
      s1_d1 <= sample.raw_pressure;
    end
    if (en[1]) begin
      s2_p_sens <= p_sens_c;
      s2_p_off  <= p_off_c;
      s2_p_temp <= p_temp_c;
      s2_dtsq   <= dtsq_c[47:0];
      s2_d1     <= s1_d1;
    end
    if (en[2]) begin
      s3_sens <= sens_c;
      s3_off  <= off_c;
      s3_tq   <= $signed(tq_adj[41:23]);
      s3_dtsq <= s2_dtsq;
      s3_d1   <= s2_d1;
    end
    if (en[3]) begin
      s4_sq1  <= sq1_full[35:0];
      s4_sq2  <= sq2_full[35:0];
      s4_low  <= low_c;
      s4_vlow <= (s3_tq < VLOW_LIMIT);
      s4_temp <= s3_tq + TEMP_BASE;
      s4_ti   <= ti_c;
      s4_sens <= s3_sens;
      s4_off  <= s3_off;
      s4_d1   <= s3_d1;
    end
    if (en[4]) begin
      s5_offi  <= offi_c;
      s5_sensi <= sensi_c;
      s5_t     <= t_out_c;
      s5_sens  <= s4_sens;
      s5_off   <= s4_off;
      s5_d1    <= s4_d1;
    end
    if (en[5]) begin
      s6_off2  <= s5_off - $signed(s5_offi);
      s6_sens2 <= s5_sens - $signed(s5_sensi);
      s6_t     <= s5_t;
      s6_d1    <= s5_d1;
    end
    if (en[6]) begin
      s7_pl   <= pl_c;
      s7_ph   <= ph_c;
      s7_off2 <= s6_off2;
      s7_t    <= s6_t;
    end
    if (en[7]) begin
      s8_prod <= prod_c;
      s8_off2 <= s7_off2;
      s8_t    <= s7_t;
    end
    if (en[8]) begin
      s9_diff <= diff_c;
      s9_t    <= s8_t;
    end
    if (en[9]) begin
      s10_res.temperature <= s9_t;
      s10_res.pressure    <= 32'($signed(p_adj[43:13]));
    end
  end

endmodule

[test/compensation_checker.sv]
`timescale 1ns / 1ps

module compensation_checker
  import ptc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_stall,
  input  sample_t                sample,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  // local copy of the calibration words
  logic [15:0] sens_c;
  logic [15:0] offset_c;
  logic [15:0] sens_tc;
  logic [15:0] offset_tc;
  logic [15:0] ref_t;
  logic [15:0] temp_c;

  result_t expected_results[$];
  int      err_count = 0;

  // first-order terms, then the banded second-order correction
  function automatic result_t compensate(sample_t s);
    longint  d1, d2, dt, sens, off, temp, ti, offi, sensi, t_out, p_out;
    result_t r;
    d1   = {40'd0, s.raw_pressure};
    d2   = {40'd0, s.raw_temperature};
    dt   = d2 - longint'({48'd0, ref_t}) * 256;
    sens = longint'({48'd0, sens_c}) * 32768 + (longint'({48'd0, sens_tc}) * dt) / 256;
    off  = longint'({48'd0, offset_c}) * 65536 + (longint'({48'd0, offset_tc}) * dt) / 128;
    temp = 2000 + (dt * longint'({48'd0, temp_c})) / 8388608;
    if (temp < 2000) begin
      ti    = (3 * (dt * dt)) / 64'sd8589934592;
      offi  = (3 * ((temp - 2000) * (temp - 2000))) / 2;
      sensi = (5 * ((temp - 2000) * (temp - 2000))) / 8;
      // very low band adds a further term
      if (temp < -1500) begin
        offi  = offi + 7 * ((temp + 1500) * (temp + 1500));
        sensi = sensi + 4 * ((temp + 1500) * (temp + 1500));
      end
    end else begin
      ti    = (2 * (dt * dt)) / 64'sd137438953472;
      offi  = ((temp - 2000) * (temp - 2000)) / 16;
      sensi = 0;
    end
    t_out = temp - ti;
    p_out = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
    r.temperature = t_out[18:0];
    r.pressure    = p_out[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      sens_c    = '0;
      offset_c  = '0;
      sens_tc   = '0;
      offset_tc = '0;
      ref_t     = '0;
      temp_c    = '0;
      expected_results.delete();
    end else begin
      // register writes, out-of-range indexes are dropped
      if (cfg_write) begin
        case (cfg_index)
          REG_SENS_COEFF:        sens_c    = cfg_data;
          REG_OFFSET_COEFF:      offset_c  = cfg_data;
          REG_SENS_TEMP_COEFF:   sens_tc   = cfg_data;
          REG_OFFSET_TEMP_COEFF: offset_tc = cfg_data;
          REG_REF_TEMP:          ref_t     = cfg_data;
          REG_TEMP_COEFF:        temp_c    = cfg_data;
          default: ;
        endcase
      end
      // compare an accepted result with the oldest prediction
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result temperature=%0d pressure=%0d",
                     $realtime, result.temperature, result.pressure);
        end else begin
          want = expected_results.pop_front();
          if (result.temperature !== want.temperature) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: temperature mismatch expected=%0d actual=%0d",
                       $realtime, want.temperature, result.temperature);
          end
          if (result.pressure !== want.pressure) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: pressure mismatch expected=%0d actual=%0d",
                       $realtime, want.pressure, result.pressure);
          end
        end
      end
      // predict each accepted reading pair
      if (sample_valid && !sample_stall)
        expected_results.push_back(compensate(sample));
    end
    mismatches  <= err_count;
    outstanding <= expected_results.size();
  end

endmodule

[test/tb_pressure_temperature_compensation_core.sv]
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation_core;
  import ptc_pkg::*;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  sample_t                sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // reference temperature word last written, used to aim readings near dT = 0
  logic [15:0] cur_ref = '0;

  always #2 clk = ~clk;

  pressure_temperature_compensation_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  compensation_checker comp_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // random back-pressure on the result side
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // present one item, with optional idle cycles ahead of it
  task automatic drive_sample(input logic [23:0] d1, input logic [23:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{raw_pressure: d1, raw_temperature: d2};
    do @(posedge clk); while (sample_stall);
  endtask

  // drop valid and wait for the pipeline to empty
  task automatic drain;
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_REF_TEMP) cur_ref = data;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] c1, input logic [15:0] c2,
                             input logic [15:0] c3, input logic [15:0] c4,
                             input logic [15:0] c5, input logic [15:0] c6);
    write_reg(REG_SENS_COEFF, c1);
    write_reg(REG_OFFSET_COEFF, c2);
    write_reg(REG_SENS_TEMP_COEFF, c3);
    write_reg(REG_OFFSET_TEMP_COEFF, c4);
    write_reg(REG_REF_TEMP, c5);
    write_reg(REG_TEMP_COEFF, c6);
    cfg_write <= 1'b0;
  endtask

  // one calibration word for a given kind of setting
  function automatic logic [15:0] pick_word(input int kind, input logic [15:0] base);
    case (kind)
      0: pick_word = base + 16'($urandom_range(2047)) - 16'd1024;
      1: pick_word = 16'($urandom);
      2: pick_word = 16'hFFFF;
      default: begin
        case ($urandom_range(2))
          0: pick_word = 16'h0000;
          1: pick_word = 16'hFFFF;
          default: pick_word = 16'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic [23:0] pick_field(input bit near_ref);
    case ($urandom_range(7))
      0: pick_field = 24'h000000;
      1: pick_field = 24'hFFFFFF;
      2: pick_field = near_ref ? ({cur_ref, 8'd0} + 24'($urandom_range(4095)) - 24'd2048)
                               : 24'($urandom);
      default: pick_field = 24'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("pressure_temperature_compensation_core test failed");
    $finish;
  end

  initial begin
    int          k;
    logic [23:0] ref24;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration, all words zero
    drive_sample(24'h000000, 24'h000000);
    drive_sample(24'hFFFFFF, 24'hFFFFFF);
    drain();

    // typical factory calibration
    load_config(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
    ref24 = {cur_ref, 8'd0};
    drive_sample(24'h000000, 24'h000000);
    drive_sample(24'hFFFFFF, 24'hFFFFFF);
    drive_sample(24'h000000, 24'hFFFFFF);
    drive_sample(24'hFFFFFF, 24'h000000);
    // high band, on the band edge and just under it
    drive_sample(24'd4958179, ref24 + 24'd1000000);
    drive_sample(24'd4958179, ref24);
    drive_sample(24'd4958179, ref24 - 24'd321);
    drive_sample(24'd4958179, ref24 - 24'd320);
    // low band
    drive_sample(24'd4958179, ref24 - 24'd300000);
    // very low band, around its edge and deep inside
    drive_sample(24'd4958179, ref24 - 24'd1123240);
    drive_sample(24'd4958179, ref24 - 24'd1123300);
    drive_sample(24'd4958179, ref24 - 24'd3000000);
    drain();

    // writes to indexes past the last register change nothing
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h0000);
    cfg_write <= 1'b0;
    drive_sample(24'd4958179, ref24 - 24'd2000000);
    drive_sample(24'hFFFFFF, ref24 + 24'd2000000);
    drain();

    // every word at its maximum
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_sample(24'h000000, 24'h000000);
    drive_sample(24'hFFFFFF, 24'hFFFFFF);
    drive_sample(24'h000000, 24'hFFFFFF);
    drive_sample(24'hFFFFFF, 24'h000000);
    drain();

    // random part: four idling phases, three calibration settings each
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int set = 0; set < 3; set++) begin
        k = (phase * 3 + set) % 4;
        load_config(pick_word(k, 16'd34982), pick_word(k, 16'd36352),
                    pick_word(k, 16'd20328), pick_word(k, 16'd22354),
                    pick_word(k, 16'd26646), pick_word(k, 16'd26146));
        if ($urandom_range(1)) begin
          write_reg(3'($urandom_range(7, 6)), 16'($urandom));
          cfg_write <= 1'b0;
        end
        for (int n = 0; n < 100; n++) begin
          drive_sample(pick_field(1'b0), pick_field(1'b1));
        end
        drain();
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("pressure_temperature_compensation_core test passed");
    end else begin
      if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
      $display("pressure_temperature_compensation_core test failed");
    end
    $finish;
  end

endmodule
